@@ rtl/fact_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fact_pkg
// Shared operation codes and controller-to-datapath command types for the
// frustum box culling test.
// ----------------------------------------------------------------------------
package fact_pkg;

    typedef enum logic [1:0] {
        OP_LOAD_CAM   = 2'd0,
        OP_LOAD_MODEL = 2'd1,
        OP_LOAD_BOX   = 2'd2,
        OP_EVALUATE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        CMD_IDLE      = 3'd0,
        CMD_MAC_CLEAR = 3'd1,
        CMD_MAC_STEP  = 3'd2,
        CMD_MVP_STORE = 3'd3,
        CMD_PL_CLEAR  = 3'd4,
        CMD_PL_STEP   = 3'd5,
        CMD_PL_CHECK  = 3'd6
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [1:0] col;
        logic [1:0] row;
        logic [1:0] k;
        logic [2:0] plane;
        logic [1:0] axis;
    } t_cmd;

    typedef struct packed {
        logic outside;
    } t_status;

endpackage
`default_nettype wire

@@ rtl/fact_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fact_datapath
// Matrix and box storage, a multiply-accumulate unit for the product
// matrix, its store and a separate multiply-accumulate for plane distances.
// ----------------------------------------------------------------------------
module fact_datapath #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [1:0]        i_wr_op,
    input  wire logic [3:0]        i_wr_index,
    input  wire logic [31:0]       i_wr_value,
    input  wire fact_pkg::t_cmd    i_cmd,
    output fact_pkg::t_status      o_status
);
    localparam int PW = 2 * WORD_BITS + 2;
    localparam int AW = PW + 3;
    localparam int CW = WORD_BITS + 1;
    localparam int DW = CW + WORD_BITS + 3;

    logic signed [WORD_BITS-1:0] r_cam [16];
    logic signed [WORD_BITS-1:0] r_mdl [16];
    logic signed [WORD_BITS-1:0] r_box [6];
    logic signed [WORD_BITS-1:0] r_mvp [16];
    logic signed [WORD_BITS-1:0] r_ma;
    logic signed [WORD_BITS-1:0] r_mb;
    logic signed [CW-1:0]        r_pa;
    logic signed [WORD_BITS-1:0] r_pb;
    logic signed [AW-1:0]        r_acc;
    logic signed [DW-1:0]        r_dist;
    logic                        r_mul_v;
    logic                        r_pmul_v;
    logic                        r_mul_v2;
    logic                        r_pmul_v2;
    logic signed [PW-1:0]        r_prod;
    logic signed [DW-1:0]        r_pprod;
    logic signed [WORD_BITS-1:0] wr_word;
    logic signed [AW-1:0]        shifted;
    logic signed [WORD_BITS-1:0] sat_word;
    logic signed [CW-1:0]        coef [4];
    logic signed [CW-1:0]        sel_coef;
    logic [1:0]                  prow;

    assign wr_word = WORD_BITS'(signed'(i_wr_value));
    assign shifted = r_acc >>> FRAC_BITS;
    assign prow    = i_cmd.plane[2:1];

    always_comb begin
        if (shifted > AW'(signed'({1'b0, {(WORD_BITS-1){1'b1}}}))) begin
            sat_word = {1'b0, {(WORD_BITS-1){1'b1}}};
        end else if (shifted < AW'(signed'({1'b1, {(WORD_BITS-1){1'b0}}}))) begin
            sat_word = {1'b1, {(WORD_BITS-1){1'b0}}};
        end else begin
            sat_word = shifted[WORD_BITS-1:0];
        end
        for (int j = 0; j < 4; j++) begin
            if (i_cmd.plane[0]) begin
                coef[j] = CW'(r_mvp[j*4+3]) - CW'(r_mvp[j*4+prow]);
            end else begin
                coef[j] = CW'(r_mvp[j*4+3]) + CW'(r_mvp[j*4+prow]);
            end
        end
        sel_coef = coef[i_cmd.axis];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            unique case (fact_pkg::t_op'(i_wr_op))
                fact_pkg::OP_LOAD_CAM:   r_cam[i_wr_index] <= wr_word;
                fact_pkg::OP_LOAD_MODEL: r_mdl[i_wr_index] <= wr_word;
                fact_pkg::OP_LOAD_BOX: begin
                    if (i_wr_index < 4'd6) begin
                        r_box[i_wr_index[2:0]] <= wr_word;
                    end
                end
                default: ;
            endcase
        end
        r_mul_v   <= (i_cmd.kind == fact_pkg::CMD_MAC_STEP);
        r_pmul_v  <= (i_cmd.kind == fact_pkg::CMD_PL_STEP);
        r_mul_v2  <= r_mul_v;
        r_pmul_v2 <= r_pmul_v;
        r_ma      <= r_cam[{i_cmd.k, i_cmd.row}];
        r_mb      <= r_mdl[{i_cmd.col, i_cmd.k}];
        r_pa      <= sel_coef;
        if (sel_coef[CW-1]) begin
            r_pb <= r_box[{1'b0, i_cmd.axis}];
        end else begin
            r_pb <= r_box[3'(i_cmd.axis) + 3'd3];
        end
        r_prod   <= PW'(r_ma) * PW'(r_mb);
        r_pprod  <= DW'(r_pa) * DW'(r_pb);
        if (i_cmd.kind == fact_pkg::CMD_MAC_CLEAR) begin
            r_acc <= AW'(1) <<< (FRAC_BITS - 1);
        end else if (r_mul_v2) begin
            r_acc <= r_acc + AW'(r_prod);
        end
        if (i_cmd.kind == fact_pkg::CMD_MVP_STORE) begin
            r_mvp[{i_cmd.col, i_cmd.row}] <= sat_word;
        end
        if (i_cmd.kind == fact_pkg::CMD_PL_CLEAR) begin
            r_dist <= DW'(coef[3]) <<< FRAC_BITS;
        end else if (r_pmul_v2) begin
            r_dist <= r_dist + r_pprod;
        end
    end

    assign o_status.outside = r_dist[DW-1];

endmodule
`default_nettype wire

@@ rtl/fact_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fact_ctrl
// Sequencer: accepts commands, issues the product and plane steps to the
// datapath and strobes the result of an evaluate.
// ----------------------------------------------------------------------------
module fact_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    input  wire logic [1:0]        i_operation,
    output logic                   busy,
    output logic                   o_wr_en,
    output fact_pkg::t_cmd         o_cmd,
    input  wire fact_pkg::t_status i_status,
    output logic                   o_valid,
    output logic                   o_inside_res
);
    typedef enum logic [2:0] {
        S_IDLE, S_MAC, S_MAC_DRAIN, S_PL_CLEAR, S_PL, S_PL_DRAIN, S_PL_CHECK
    } t_state;

    t_state         r_state;
    fact_pkg::t_cmd r_cmd;
    logic [1:0]     r_wait;
    logic           r_valid;
    logic           r_inside;

    assign busy         = (r_state != S_IDLE);
    assign o_wr_en      = start && !busy;
    assign o_cmd        = r_cmd;
    assign o_valid      = r_valid;
    assign o_inside_res = r_inside;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cmd    <= '0;
            r_wait   <= '0;
            r_valid  <= 1'b0;
            r_inside <= 1'b0;
        end else begin
            r_valid <= (r_state == S_PL_CHECK) &&
                       (i_status.outside || r_cmd.plane == 3'd5);
            unique case (r_state)
                S_IDLE: begin
                    if (o_wr_en && fact_pkg::t_op'(i_operation) == fact_pkg::OP_EVALUATE) begin
                        r_cmd.kind  <= fact_pkg::CMD_MAC_CLEAR;
                        r_cmd.col   <= 2'd0;
                        r_cmd.row   <= 2'd0;
                        r_cmd.k     <= 2'd0;
                        r_cmd.plane <= 3'd0;
                        r_cmd.axis  <= 2'd0;
                        r_state     <= S_MAC;
                    end else begin
                        r_cmd.kind <= fact_pkg::CMD_IDLE;
                    end
                end
                S_MAC: begin
                    if (r_cmd.kind == fact_pkg::CMD_MAC_STEP) begin
                        r_cmd.k <= r_cmd.k + 2'd1;
                        if (r_cmd.k == 2'd3) begin
                            r_cmd.kind <= fact_pkg::CMD_IDLE;
                            r_wait     <= 2'd0;
                            r_state    <= S_MAC_DRAIN;
                        end
                    end else begin
                        r_cmd.kind <= fact_pkg::CMD_MAC_STEP;
                    end
                end
                S_MAC_DRAIN: begin
                    if (r_cmd.kind == fact_pkg::CMD_MVP_STORE) begin
                        {r_cmd.col, r_cmd.row} <= {r_cmd.col, r_cmd.row} + 4'd1;
                        if ({r_cmd.col, r_cmd.row} == 4'd15) begin
                            r_cmd.kind  <= fact_pkg::CMD_IDLE;
                            r_cmd.plane <= 3'd0;
                            r_state     <= S_PL_CLEAR;
                        end else begin
                            r_cmd.kind <= fact_pkg::CMD_MAC_CLEAR;
                            r_state    <= S_MAC;
                        end
                    end else begin
                        r_wait <= r_wait + 2'd1;
                        if (r_wait == 2'd2) begin
                            r_cmd.kind <= fact_pkg::CMD_MVP_STORE;
                        end
                    end
                end
                S_PL_CLEAR: begin
                    r_cmd.kind <= fact_pkg::CMD_PL_CLEAR;
                    r_cmd.axis <= 2'd0;
                    r_state    <= S_PL;
                end
                S_PL: begin
                    if (r_cmd.kind == fact_pkg::CMD_PL_STEP) begin
                        if (r_cmd.axis == 2'd2) begin
                            r_cmd.kind <= fact_pkg::CMD_IDLE;
                            r_cmd.axis <= 2'd0;
                            r_wait     <= 2'd0;
                            r_state    <= S_PL_DRAIN;
                        end else begin
                            r_cmd.axis <= r_cmd.axis + 2'd1;
                        end
                    end else begin
                        r_cmd.kind <= fact_pkg::CMD_PL_STEP;
                    end
                end
                S_PL_DRAIN: begin
                    r_wait <= r_wait + 2'd1;
                    if (r_wait == 2'd2) begin
                        r_state <= S_PL_CHECK;
                    end
                end
                S_PL_CHECK: begin
                    if (i_status.outside || r_cmd.plane == 3'd5) begin
                        r_inside <= !i_status.outside;
                        r_state  <= S_IDLE;
                    end else begin
                        r_cmd.plane <= r_cmd.plane + 3'd1;
                        r_state     <= S_PL_CLEAR;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ rtl/frustum_aabb_cull_test_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// frustum_aabb_cull_test_core
// Frustum visibility test of an axis-aligned box.
//
// Usage: drive i_operation, i_index, i_value with start high; the transfer
// takes place on a clock edge where busy is low. Loads of camera, model and
// box words are written at that edge and return nothing. An evaluate raises
// busy while one shared multiply-accumulate unit forms the 16 product
// elements and a separate plane multiply-accumulate then tests up to six
// planes, stopping at the first plane the box is outside. o_valid pulses
// one cycle with o_inside_res at the end of the evaluate, and busy falls
// with it. The receiver cannot stall. Loads sustain one per cycle while
// busy is low.
// Reset (synchronous, active low) returns the controller to idle; the
// stored matrices and bounds keep no reset value and must be loaded.
// ----------------------------------------------------------------------------
module frustum_aabb_cull_test_core #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_operation,
    input  wire logic [3:0]  i_index,
    input  wire logic [31:0] i_value,
    output logic             o_valid,
    output logic             o_inside_res
);
    logic              wr_en;
    fact_pkg::t_cmd    cmd;
    fact_pkg::t_status status;

    fact_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_operation  (i_operation),
        .busy         (busy),
        .o_wr_en      (wr_en),
        .o_cmd        (cmd),
        .i_status     (status),
        .o_valid      (o_valid),
        .o_inside_res (o_inside_res)
    );

    fact_datapath #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_wr_en    (wr_en),
        .i_wr_op    (i_operation),
        .i_wr_index (i_index),
        .i_wr_value (i_value),
        .i_cmd      (cmd),
        .o_status   (status)
    );

endmodule
`default_nettype wire
